// ===== hdl/thermistor_steinhart_hart_temp_defines.svh =====
// Assertion macros for the thermistor Steinhart-Hart converter.
// Taken in by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef THERMISTOR_STEINHART_HART_TEMP_DEFINES_SVH
`define THERMISTOR_STEINHART_HART_TEMP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TSH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tsh_pkg.sv =====
// Shared types, constants and the log table rule for the thermistor converter.
// No dependencies; used by tsh_core and the top level.
package tsh_pkg;

  localparam int RES_WIDTH      = 24;
  localparam int LOG_TABLE_BITS = 8;
  localparam int TBL_SIZE       = 1 << LOG_TABLE_BITS;
  localparam int REM_BITS       = 31 - LOG_TABLE_BITS;
  localparam int ADDR_W         = 5;
  localparam int Q_BITS         = 16;

  localparam logic [26:0] LN2_Q27      = 27'd93032640;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [15:0] KELVIN_CENTI = 16'd27315;
  localparam logic [15:0] TEMP_MAX_Q   = 16'd60082;

  localparam logic signed [31:0] COEFF_A_RESET = 32'sd1241613610;
  localparam logic signed [31:0] COEFF_B_RESET = 32'sd257404138;
  localparam logic signed [39:0] COEFF_C_RESET = 40'sd6323391106;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_ZERO    = 3'd2,
    STAT_DEN     = 3'd3,
    STAT_SAT     = 3'd4
  } tsh_status_t;

  typedef enum logic [1:0] {
    REG_COEFF_A = 2'd0,
    REG_COEFF_B = 2'd1,
    REG_COEFF_C = 2'd2
  } tsh_reg_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [39:0] c;
  } tsh_coeff_t;

  // ln(1 + i/2^LOG_TABLE_BITS) in Q.27, via repeated squaring for log2
  function automatic logic [26:0] rom_ln(int unsigned i);
    logic [63:0] y;
    logic [31:0] f;
    logic [63:0] prod;
    int          n;
    if (i >= TBL_SIZE) return LN2_Q27;
    y = (64'd1 << 31) + (64'(i) << REM_BITS);
    f = '0;
    for (n = 0; n < 32; n++) begin
      y = (y * y) >> 31;
      f = f << 1;
      if (y >= (64'd1 << 32)) begin
        y = y >> 1;
        f[0] = 1'b1;
      end
    end
    prod = 64'(f) * 64'(LN2_Q32) + (64'd1 << 36);
    return 27'(prod >> 37);
  endfunction

endpackage

// ===== hdl/thermistor_steinhart_hart_temp.sv =====
// Top level: APB coefficient registers and the conversion pipeline.
// Depends on tsh_pkg and tsh_core.
//
// Converts a thermistor resistance to Celsius in hundredths of a degree with the
// Steinhart-Hart equation. One transaction is accepted every cycle while the
// output buffer has room. The path holds 28 registers (9 stages for log and
// polynomial, 17 for the bit-per-stage reciprocal divider, one offset and
// saturation stage, the output register); the first of them loads on the
// accepting edge. A two-entry output buffer lets the pipeline keep running while
// one result waits; input ready drops only when both entries are full.
// Coefficients sit at byte addresses 0, 8 and 16 (64-bit data) and should be
// written only while no conversion is in flight.
module thermistor_steinhart_hart_temp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsh_pkg::ADDR_W-1:0]     paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tsh_pkg::RES_WIDTH-1:0]  resistance_ohms,
  input  logic                           sample_ok,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             temp_centi_c,
  output logic [2:0]                     status
);

  tsh_pkg::tsh_coeff_t coeff;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  // coefficient register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff.a <= tsh_pkg::COEFF_A_RESET;
      coeff.b <= tsh_pkg::COEFF_B_RESET;
      coeff.c <= tsh_pkg::COEFF_C_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        tsh_pkg::REG_COEFF_A: coeff.a <= $signed(pwdata[31:0]);
        tsh_pkg::REG_COEFF_B: coeff.b <= $signed(pwdata[31:0]);
        tsh_pkg::REG_COEFF_C: coeff.c <= $signed(pwdata[39:0]);
        default: ;
      endcase
    end
  end

  // read back, sign extended
  always_comb begin
    unique case (reg_idx)
      tsh_pkg::REG_COEFF_A: prdata = 64'(coeff.a);
      tsh_pkg::REG_COEFF_B: prdata = 64'(coeff.b);
      tsh_pkg::REG_COEFF_C: prdata = 64'(coeff.c);
      default:              prdata = '0;
    endcase
  end

  tsh_core u_core (
    .clk             (clk),
    .rst             (rst),
    .coeff           (coeff),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .resistance_ohms (resistance_ohms),
    .sample_ok       (sample_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temp_centi_c    (temp_centi_c),
    .status          (status)
  );

endmodule

// ===== hdl/tsh_core.sv =====
// Pipelined datapath: log, Steinhart-Hart polynomial, rounded reciprocal, output buffer.
// Depends on tsh_pkg and thermistor_steinhart_hart_temp_defines.svh.
`include "thermistor_steinhart_hart_temp_defines.svh"

module tsh_core (
  input  logic                              clk,
  input  logic                              rst,
  input  tsh_pkg::tsh_coeff_t               coeff,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tsh_pkg::RES_WIDTH-1:0]     resistance_ohms,
  input  logic                              sample_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                temp_centi_c,
  output logic [2:0]                        status
);

  localparam int RW      = tsh_pkg::RES_WIDTH;
  localparam int LTB     = tsh_pkg::LOG_TABLE_BITS;
  localparam int RB      = tsh_pkg::REM_BITS;
  localparam int QB      = tsh_pkg::Q_BITS;
  localparam int ST_DIV0 = 9;
  localparam int ST_FIN  = ST_DIV0 + QB + 1;
  localparam int NSTG    = ST_FIN + 1;
  localparam int IP_W    = 27 + RB;
  localparam int CUBE_W  = 41;
  localparam logic [63:0] NUM_BASE = 64'd100 << 56;

  logic            en;
  logic [NSTG-1:0] v;

  // log table, built at elaboration
  logic [26:0] ln_rom [0:tsh_pkg::TBL_SIZE];
  for (genvar g = 0; g <= tsh_pkg::TBL_SIZE; g++) begin : g_rom
    assign ln_rom[g] = tsh_pkg::rom_ln(g);
  end

  // valid bits shift with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTG-2:0], in_valid};
    end
  end

  assign in_ready = en;

  // stage 0: capture transaction
  logic [RW-1:0] r0;
  logic          ok0;
  always_ff @(posedge clk) begin
    if (en) begin
      r0  <= resistance_ohms;
      ok0 <= sample_ok;
    end
  end

  // leading-one search and normalize
  logic [4:0]  lead;
  logic [31:0] xnorm;
  tsh_pkg::tsh_status_t st0_c;
  always_comb begin
    lead = '0;
    for (int i = 0; i < RW; i++) begin
      if (r0[i]) lead = 5'(i);
    end
    xnorm = 32'(r0) << (5'd31 - lead);
    if (!ok0) st0_c = tsh_pkg::STAT_INVALID;
    else if (r0 == '0) st0_c = tsh_pkg::STAT_ZERO;
    else st0_c = tsh_pkg::STAT_OK;
  end

  logic [4:0]  p1;
  logic [30:0] frac1;
  tsh_pkg::tsh_status_t st1;
  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= lead;
      frac1 <= xnorm[30:0];
      st1   <= st0_c;
    end
  end

  // table lookup and exponent term
  logic [LTB-1:0] idx1;
  logic [26:0]    t0_c, t1_c;
  assign idx1 = frac1[30 -: LTB];
  assign t0_c = ln_rom[{1'b0, idx1}];
  assign t1_c = ln_rom[(LTB+1)'(idx1) + (LTB+1)'(1)];

  logic [31:0]   pl2;
  logic [26:0]   t0_2, dt2;
  logic [RB-1:0] rem2;
  tsh_pkg::tsh_status_t st2;
  always_ff @(posedge clk) begin
    if (en) begin
      pl2  <= 32'(p1) * 32'(tsh_pkg::LN2_Q27);
      t0_2 <= t0_c;
      dt2  <= t1_c - t0_c;
      rem2 <= frac1[RB-1:0];
      st2  <= st1;
    end
  end

  // linear interpolation, rounded half up
  logic [IP_W-1:0] ip_prod;
  logic [26:0]     interp;
  assign ip_prod = IP_W'(dt2) * IP_W'(rem2) + (IP_W'(1) << (RB - 1));
  assign interp  = 27'(ip_prod >> RB);

  logic [31:0] lnr3;
  tsh_pkg::tsh_status_t st3;
  always_ff @(posedge clk) begin
    if (en) begin
      lnr3 <= pl2 + 32'(t0_2) + 32'(interp);
      st3  <= st2;
    end
  end

  // square and B product
  logic [63:0]        sq_prod;
  logic signed [64:0] b_prod;
  assign sq_prod = 64'(lnr3) * 64'(lnr3);
  assign b_prod  = 65'(coeff.b) * $signed({1'b0, lnr3});

  logic [35:0]        sq4;
  logic signed [64:0] bprod4;
  logic [31:0]        lnr4;
  tsh_pkg::tsh_status_t st4;
  always_ff @(posedge clk) begin
    if (en) begin
      sq4    <= sq_prod[62:27];
      bprod4 <= b_prod;
      lnr4   <= lnr3;
      st4    <= st3;
    end
  end

  // cube, B term truncated toward zero, plus A
  logic [63:0]        cube_prod;
  logic signed [64:0] b_bias;
  logic signed [64:0] b_term;
  assign cube_prod = 64'(sq4[35:4]) * 64'(lnr4);
  assign b_bias    = bprod4[64] ? 65'sd2047 : 65'sd0;
  assign b_term    = (bprod4 + b_bias) >>> 11;

  logic [CUBE_W-1:0]  cube5;
  logic signed [63:0] ab5;
  tsh_pkg::tsh_status_t st5;
  always_ff @(posedge clk) begin
    if (en) begin
      cube5 <= cube_prod[63:23];
      ab5   <= (64'(coeff.a) <<< 16) + 64'(b_term);
      st5   <= st4;
    end
  end

  // C times cube in two partial products
  logic signed [61:0] pplo6;
  logic signed [60:0] pphi6;
  logic signed [63:0] ab6;
  tsh_pkg::tsh_status_t st6;
  always_ff @(posedge clk) begin
    if (en) begin
      pplo6 <= 62'(coeff.c) * $signed({1'b0, cube5[20:0]});
      pphi6 <= 61'(coeff.c) * $signed({1'b0, cube5[40:21]});
      ab6   <= ab5;
      st6   <= st5;
    end
  end

  logic signed [81:0] cprod7;
  logic signed [63:0] ab7;
  tsh_pkg::tsh_status_t st7;
  always_ff @(posedge clk) begin
    if (en) begin
      cprod7 <= (82'(pphi6) <<< 21) + 82'(pplo6);
      ab7    <= ab6;
      st7    <= st6;
    end
  end

  // C term truncated toward zero, denominator sum
  logic signed [81:0] c_bias;
  logic signed [81:0] c_term;
  assign c_bias = cprod7[81] ? 82'sd134217727 : 82'sd0;
  assign c_term = (cprod7 + c_bias) >>> 27;

  logic signed [63:0] den8;
  tsh_pkg::tsh_status_t st8;
  always_ff @(posedge clk) begin
    if (en) begin
      den8 <= ab7 + 64'(c_term);
      st8  <= st7;
    end
  end

  // numerator with half-divisor rounding, quotient range check
  logic [63:0] num8;
  logic        ovf8;
  tsh_pkg::tsh_status_t st8_c;
  assign num8 = NUM_BASE + 64'(den8[62:1]);
  assign ovf8 = {16'b0, num8} >= {1'b0, den8[62:0], 16'b0};
  always_comb begin
    if (st8 == tsh_pkg::STAT_OK && (den8[63] || den8 == '0)) st8_c = tsh_pkg::STAT_DEN;
    else st8_c = st8;
  end

  // restoring divider, one quotient bit per stage
  logic [79:0]   dv_rem [0:QB];
  logic [62:0]   dv_den [0:QB];
  logic [QB-1:0] dv_q   [0:QB];
  logic          dv_ovf [0:QB];
  tsh_pkg::tsh_status_t dv_st [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= {16'b0, num8};
      dv_den[0] <= den8[62:0];
      dv_q[0]   <= '0;
      dv_ovf[0] <= ovf8;
      dv_st[0]  <= st8_c;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [79:0]   trial;
    logic          take;
    logic [QB-1:0] qbit;
    assign trial = 80'(dv_den[j]) << (QB - 1 - j);
    assign take  = dv_rem[j] >= trial;
    assign qbit  = QB'(take) << (QB - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[j+1] <= take ? dv_rem[j] - trial : dv_rem[j];
        dv_den[j+1] <= dv_den[j];
        dv_q[j+1]   <= dv_q[j] | qbit;
        dv_ovf[j+1] <= dv_ovf[j];
        dv_st[j+1]  <= dv_st[j];
      end
    end
  end

  // Celsius offset and saturation
  tsh_pkg::tsh_status_t fin_st_c;
  logic [15:0]          fin_t_c;
  always_comb begin
    fin_st_c = dv_st[QB];
    fin_t_c  = '0;
    if (dv_st[QB] == tsh_pkg::STAT_OK) begin
      if (dv_ovf[QB] || dv_q[QB] > tsh_pkg::TEMP_MAX_Q) fin_st_c = tsh_pkg::STAT_SAT;
      else fin_t_c = dv_q[QB] - tsh_pkg::KELVIN_CENTI;
    end
  end

  logic [15:0]          fin_t;
  tsh_pkg::tsh_status_t fin_st;
  always_ff @(posedge clk) begin
    if (en) begin
      fin_t  <= fin_t_c;
      fin_st <= fin_st_c;
    end
  end

  // two-entry output buffer; pipeline advances while the spare is empty
  logic        out_v, sp_v;
  logic [15:0] out_t, sp_t;
  logic [2:0]  out_s, sp_s;

  assign en = !sp_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sp_v  <= 1'b0;
    end else if (out_ready || !out_v) begin
      if (sp_v) begin
        out_t <= sp_t;
        out_s <= sp_s;
        out_v <= 1'b1;
        sp_v  <= 1'b0;
      end else if (v[ST_FIN]) begin
        out_t <= fin_t;
        out_s <= fin_st;
        out_v <= 1'b1;
      end else begin
        out_v <= 1'b0;
      end
    end else if (v[ST_FIN] && !sp_v) begin
      // last stage is held while the spare is full
      sp_t <= fin_t;
      sp_s <= fin_st;
      sp_v <= 1'b1;
    end
  end

  assign out_valid    = out_v;
  assign temp_centi_c = $signed(out_t);
  assign status       = out_s;

  `TSH_ASSERT_SAME(a_zero_on_err, out_valid && status != tsh_pkg::STAT_OK, temp_centi_c == 16'sd0, "temperature nonzero with error status")
  `TSH_ASSERT_SAME(a_stall_src, !in_ready, out_valid, "input stalled while output empty")
  `TSH_ASSERT_SAME(a_spare_fill, $rose(sp_v), $past(out_valid && !out_ready), "spare filled without output stall")
  `TSH_ASSERT_SAME(a_div_den, v[ST_DIV0] && dv_st[0] == tsh_pkg::STAT_OK, dv_den[0] != '0, "zero divisor entered divider")

endmodule

// ===== bench/tb_thermistor_steinhart_hart_temp.sv =====
// Self-checking testbench for the Steinhart-Hart thermistor converter.
// Depends on tsh_pkg and thermistor_steinhart_hart_temp; predicts each conversion.
`timescale 1ns / 100ps

module tb_thermistor_steinhart_hart_temp;

  typedef struct {
    logic signed [15:0]   temp;
    tsh_pkg::tsh_status_t status;
  } temp_result_t;

  // Expected conversions in arrival order, compared against the output channel
  class temp_scoreboard;
    temp_result_t pending[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function void note_input(temp_result_t e);
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] t, logic [2:0] s);
      temp_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result temp=%0d status=%0d", $time, t, s);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (t !== e.temp) begin
        $display("%0t: temp mismatch expected %0d actual %0d", $time, e.temp, t);
        errors++;
      end
      if (s !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, s);
        errors++;
      end
    endfunction
  endclass

  localparam logic [tsh_pkg::ADDR_W-1:0] ADDR_UNUSED = 5'd24;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tsh_pkg::ADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [tsh_pkg::RES_WIDTH-1:0] resistance_ohms = '0;
  logic sample_ok = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] temp_centi_c;
  logic [2:0] status;

  // Predictor copy of the coefficient registers
  logic signed [31:0] model_a = tsh_pkg::COEFF_A_RESET;
  logic signed [31:0] model_b = tsh_pkg::COEFF_B_RESET;
  logic signed [39:0] model_c = tsh_pkg::COEFF_C_RESET;
  logic [63:0] ln_tbl [0:tsh_pkg::TBL_SIZE];

  temp_scoreboard sb = new();
  int  stall_req = 0;
  bit  no_idle = 0;

  thermistor_steinhart_hart_temp dut (.*);

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // log2 by repeated squaring, scaled to natural log in Q.27
  function automatic void build_ln_table();
    logic [127:0] y, f;
    for (int i = 0; i < tsh_pkg::TBL_SIZE; i++) begin
      y = (128'd1 << 31) + (128'(i) << tsh_pkg::REM_BITS);
      f = '0;
      for (int n = 0; n < 32; n++) begin
        y = (y * y) >> 31;
        f = f << 1;
        if (y >= (128'd1 << 32)) begin
          y = y >> 1;
          f = f | 128'd1;
        end
      end
      ln_tbl[i] = 64'((f * 128'(tsh_pkg::LN2_Q32) + (128'd1 << 36)) >> 37);
    end
    ln_tbl[tsh_pkg::TBL_SIZE] = 64'(tsh_pkg::LN2_Q27);
  endfunction

  function automatic temp_result_t predict_temp(logic [tsh_pkg::RES_WIDTH-1:0] r, logic ok);
    temp_result_t res;
    int p;
    logic [63:0] n, frac, rem, idx, lnr, sq, cube;
    logic signed [127:0] pb, pc, den, q;
    res.temp = '0;
    res.status = tsh_pkg::STAT_OK;
    if (!ok) begin
      res.status = tsh_pkg::STAT_INVALID;
      return res;
    end
    if (r == 0) begin
      res.status = tsh_pkg::STAT_ZERO;
      return res;
    end
    p = 0;
    for (int k = 0; k < tsh_pkg::RES_WIDTH; k++) if (r[k]) p = k;
    n = (64'(r) << (31 - p)) & 64'hFFFF_FFFF;
    frac = n - (64'd1 << 31);
    idx = frac >> tsh_pkg::REM_BITS;
    rem = frac & ((64'd1 << tsh_pkg::REM_BITS) - 1);
    lnr = 64'(p) * 64'(tsh_pkg::LN2_Q27) + ln_tbl[idx] +
          (((ln_tbl[idx + 1] - ln_tbl[idx]) * rem + (64'd1 << (tsh_pkg::REM_BITS - 1)))
           >> tsh_pkg::REM_BITS);
    sq = (lnr * lnr) >> 27;
    cube = ((sq >> 4) * lnr) >> 23;
    // products truncate toward zero
    pb = 128'(model_b) * $signed({64'd0, lnr});
    pb = (pb < 0) ? -((-pb) >>> 11) : (pb >>> 11);
    pc = 128'(model_c) * $signed({64'd0, cube});
    pc = (pc < 0) ? -((-pc) >>> 27) : (pc >>> 27);
    den = (128'(model_a) <<< 16) + pb + pc;
    if (den <= 0) begin
      res.status = tsh_pkg::STAT_DEN;
      return res;
    end
    q = ((128'sd100 <<< 56) + (den >>> 1)) / den;
    if (q > 128'(tsh_pkg::TEMP_MAX_Q)) res.status = tsh_pkg::STAT_SAT;
    else res.temp = 16'(q - 128'(tsh_pkg::KELVIN_CENTI));
    return res;
  endfunction

  // Transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(predict_temp(resistance_ohms, sample_ok));
    if (!rst && out_valid && out_ready) sb.check_result(temp_centi_c, status);
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random back-pressure plus requested long hold-offs
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (stall_req > 0) begin
        out_ready <= 1'b0;
        stall_req = stall_req - 1;
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        hold = pick_gap();
        out_ready <= (hold == 0);
      end
    end
  end

  task automatic send_sample(logic [tsh_pkg::RES_WIDTH-1:0] r, logic ok);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    resistance_ohms <= r;
    sample_ok <= ok;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(int count);
    logic [tsh_pkg::RES_WIDTH-1:0] r;
    int w;
    repeat (count) begin
      w = $urandom_range(1, tsh_pkg::RES_WIDTH);
      r = tsh_pkg::RES_WIDTH'($urandom) & tsh_pkg::RES_WIDTH'((64'd1 << w) - 1);
      if ($urandom_range(0, 49) == 0) r = '0;
      send_sample(r, $urandom_range(0, 9) != 0);
    end
  endtask

  // Wait for all conversions out, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [tsh_pkg::ADDR_W-1:0] addr, logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      {tsh_pkg::REG_COEFF_A, 3'b000}: model_a = data[31:0];
      {tsh_pkg::REG_COEFF_B, 3'b000}: model_b = data[31:0];
      {tsh_pkg::REG_COEFF_C, 3'b000}: model_c = data[39:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_coeffs(logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [39:0] c);
    apb_write({tsh_pkg::REG_COEFF_A, 3'b000}, 64'(a));
    apb_write({tsh_pkg::REG_COEFF_B, 3'b000}, 64'(b));
    apb_write({tsh_pkg::REG_COEFF_C, 3'b000}, 64'(c));
  endtask

  initial begin
    build_ln_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, invalid sample, zero resistance, saturation at R=1
    apb_write(ADDR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample('0, 1'b1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample('1, 1'b1);
    send_sample(24'd1, 1'b1);
    send_sample(24'd2, 1'b1);
    send_sample(24'd3, 1'b1);
    send_sample(24'd100, 1'b1);
    send_sample(24'd1000, 1'b1);
    send_sample(24'd10000, 1'b1);
    send_sample(24'd100000, 1'b1);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'hAAAAAA, 1'b1);
    send_sample(24'h555555, 1'b1);
    drain();

    // Extreme coefficients: huge denominator, then negative, then tiny
    set_coeffs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 40'sh7F_FFFF_FFFF);
    send_sample(24'd1, 1'b1);
    send_sample('1, 1'b1);
    drain();
    set_coeffs(32'sh8000_0000, 32'sh8000_0000, 40'sh80_0000_0000);
    send_sample(24'd5000, 1'b1);
    send_sample('1, 1'b1);
    drain();
    set_coeffs(32'sd0, 32'sd0, 40'sd1);
    send_sample(24'd1, 1'b1);
    send_sample(24'd40000, 1'b1);
    drain();

    // Default coefficients with random traffic
    set_coeffs(tsh_pkg::COEFF_A_RESET, tsh_pkg::COEFF_B_RESET, tsh_pkg::COEFF_C_RESET);
    send_random(180);
    drain();

    // Perturbed coefficients around the defaults
    repeat (2) begin
      set_coeffs(tsh_pkg::COEFF_A_RESET + $signed(32'($urandom_range(0, 400000000)))
                   - 200000000,
                 tsh_pkg::COEFF_B_RESET + $signed(32'($urandom_range(0, 100000000)))
                   - 50000000,
                 tsh_pkg::COEFF_C_RESET + $signed(40'($urandom_range(0, 4000000000)))
                   - 2000000000);
      send_random(90);
      drain();
    end

    // Fully random coefficients
    set_coeffs($urandom, $urandom, 40'({$urandom, $urandom}));
    send_random(60);
    drain();

    // Long receiver hold-off while the sender streams back to back
    set_coeffs(tsh_pkg::COEFF_A_RESET, tsh_pkg::COEFF_B_RESET, tsh_pkg::COEFF_C_RESET);
    no_idle = 1;
    stall_req = 200;
    send_random(60);
    no_idle = 0;
    send_random(40);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tsh_pkg.sv
hdl/tsh_core.sv
hdl/thermistor_steinhart_hart_temp.sv
bench/tb_thermistor_steinhart_hart_temp.sv
